### hw/rtl/mslcg_pkg.sv
// ----------------------------------------------------------------------------
// mslcg_pkg
// Shared types, constants and the control store of the minimal standard
// generator with a normal draw.
// ----------------------------------------------------------------------------
package mslcg_pkg;

    // Generator arithmetic
    localparam int          SEED_W    = 31;
    localparam int          MUL_W     = 15;
    localparam int          SUM_W     = 34;
    localparam int          MAG_W     = 33;
    localparam int          SCALE_W   = 29;
    localparam int          PROD_W    = MAG_W + SCALE_W;
    localparam int          NORM_W    = 32;
    localparam int          SUM_TERMS = 6;

    localparam logic [MUL_W-1:0]   LCG_MUL   = 15'd16807;
    localparam logic [SEED_W-1:0]  LCG_MOD   = 31'h7FFF_FFFF;
    // Midpoint of a six-term sum: 3 * modulus
    localparam logic [SUM_W-1:0]   CENTRE    = 34'd6442450941;
    // 1.414213562 in Q.28
    localparam logic [SCALE_W-1:0] SCALE_Q28 = 29'd379625062;

    // Configuration port
    localparam int              ADDR_W          = 2;
    localparam int              DATA_W          = 32;
    localparam logic [ADDR_W-1:0] ADDR_START_SEED = 2'd0;

    // Sequencer
    localparam int            PC_W          = 4;
    localparam logic [PC_W-1:0] PC_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] PC_STEP_FIRST = 4'd1;
    localparam logic [PC_W-1:0] PC_EMIT       = 4'd11;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_START,
        OP_STEP,
        OP_MAG,
        OP_MUL,
        OP_FOLD,
        OP_QUOT
    } op_t;

    // Sequencing conditions
    typedef enum logic [2:0] {
        COND_NEXT,   // fall through
        COND_TAKE,   // hold until an input transfer, then fall through
        COND_UNIF,   // jump to target on a uniform request
        COND_FREE,   // hold until the output register is free, then jump
        COND_JUMP    // unconditional jump
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic             emit;
    } ctrl_word_t;

    // Datapath control from the sequencer
    typedef struct packed {
        op_t               op;
        logic              seed_load;
        logic [SEED_W-1:0] seed_data;
    } dp_ctrl_t;

    // Control store: six steps for a normal draw, early exit for uniform
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: COND_JUMP, target: PC_IDLE, emit: 1'b0};
        case (pc)
            4'd0:  w = '{op: OP_START, cond: COND_TAKE, target: PC_IDLE, emit: 1'b0};
            4'd1:  w = '{op: OP_STEP,  cond: COND_UNIF, target: PC_EMIT, emit: 1'b0};
            4'd2:  w = '{op: OP_STEP,  cond: COND_NEXT, target: PC_IDLE, emit: 1'b0};
            4'd3:  w = '{op: OP_STEP,  cond: COND_NEXT, target: PC_IDLE, emit: 1'b0};
            4'd4:  w = '{op: OP_STEP,  cond: COND_NEXT, target: PC_IDLE, emit: 1'b0};
            4'd5:  w = '{op: OP_STEP,  cond: COND_NEXT, target: PC_IDLE, emit: 1'b0};
            4'd6:  w = '{op: OP_STEP,  cond: COND_NEXT, target: PC_IDLE, emit: 1'b0};
            4'd7:  w = '{op: OP_MAG,   cond: COND_NEXT, target: PC_IDLE, emit: 1'b0};
            4'd8:  w = '{op: OP_MUL,   cond: COND_NEXT, target: PC_IDLE, emit: 1'b0};
            4'd9:  w = '{op: OP_FOLD,  cond: COND_NEXT, target: PC_IDLE, emit: 1'b0};
            4'd10: w = '{op: OP_QUOT,  cond: COND_NEXT, target: PC_IDLE, emit: 1'b0};
            4'd11: w = '{op: OP_NOP,   cond: COND_FREE, target: PC_IDLE, emit: 1'b1};
            default: w = '{op: OP_NOP, cond: COND_JUMP, target: PC_IDLE, emit: 1'b0};
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/mslcg_dp.sv
// ----------------------------------------------------------------------------
// mslcg_dp
// Datapath: seed register with the multiply-mod unit, six-term accumulator,
// and the scale-and-divide chain that forms the Q3.28 normal value.
// ----------------------------------------------------------------------------
module mslcg_dp
    import mslcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_ctrl_t          ctrl,
    output logic [SEED_W-1:0] seed,
    output logic [NORM_W-1:0] norm
);

    logic [SEED_W-1:0]  seed_reg, seed_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [SEED_W-1:0]  q0_reg, q0_next;
    logic [SEED_W:0]    tsum_reg, tsum_next;
    logic [NORM_W-1:0]  norm_reg, norm_next;

    logic [MUL_W+SEED_W-1:0] lcg_prod;
    logic [SEED_W:0]         lcg_fold;
    logic [SEED_W-1:0]       lcg_new;
    logic [SEED_W-1:0]       load_val;
    logic [SEED_W:0]         rem;
    logic [NORM_W-1:0]       quot;

    // Multiply-mod step: 2^31 = 1 mod (2^31-1), so fold high into low
    always_comb
    begin
        lcg_prod = {{SEED_W{1'b0}}, LCG_MUL} * {{MUL_W{1'b0}}, seed_reg};
        lcg_fold = {1'b0, lcg_prod[SEED_W-1:0]}
                 + {{(SEED_W+1-MUL_W){1'b0}}, lcg_prod[MUL_W+SEED_W-1:SEED_W]};
        if (lcg_fold >= {1'b0, LCG_MOD})
            lcg_new = lcg_fold[SEED_W-1:0] - LCG_MOD;
        else
            lcg_new = lcg_fold[SEED_W-1:0];
    end

    // Loaded seed: zero and the modulus itself both become one
    always_comb
    begin
        if (ctrl.seed_data == '0 || ctrl.seed_data == LCG_MOD)
            load_val = {{(SEED_W-1){1'b0}}, 1'b1};
        else
            load_val = ctrl.seed_data;
    end

    // Quotient by 2^31-1 from the folded product
    always_comb
    begin
        rem  = {1'b0, tsum_reg[SEED_W-1:0]} + {{SEED_W{1'b0}}, tsum_reg[SEED_W]};
        quot = {1'b0, q0_reg} + {{SEED_W{1'b0}}, tsum_reg[SEED_W]}
             + {{SEED_W{1'b0}}, (rem >= {1'b0, LCG_MOD})};
    end

    // Operation decode
    always_comb
    begin
        seed_next = seed_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        prod_next = prod_reg;
        q0_next   = q0_reg;
        tsum_next = tsum_reg;
        norm_next = norm_reg;
        case (ctrl.op)
            OP_START:
            begin
                acc_next  = '0;
                norm_next = '0;
            end
            OP_STEP:
            begin
                seed_next = lcg_new;
                acc_next  = acc_reg + {{(SUM_W-SEED_W){1'b0}}, lcg_new};
            end
            OP_MAG:
            begin
                neg_next = (acc_reg < CENTRE);
                if (acc_reg < CENTRE)
                    mag_next = MAG_W'(CENTRE - acc_reg);
                else
                    mag_next = MAG_W'(acc_reg - CENTRE);
            end
            OP_MUL:
            begin
                prod_next = {{SCALE_W{1'b0}}, mag_reg} * {{MAG_W{1'b0}}, SCALE_Q28};
            end
            OP_FOLD:
            begin
                q0_next   = prod_reg[PROD_W-1:SEED_W];
                tsum_next = {1'b0, prod_reg[PROD_W-1:SEED_W]}
                          + {1'b0, prod_reg[SEED_W-1:0]};
            end
            OP_QUOT:
            begin
                norm_next = neg_reg ? (~quot + 1'b1) : quot;
            end
            default:
            begin
                seed_next = seed_reg;
            end
        endcase
        if (ctrl.seed_load)
            seed_next = load_val;
    end

    // Generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= {{(SEED_W-1){1'b0}}, 1'b1};
        else
            seed_reg <= seed_next;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        q0_reg   <= q0_next;
        tsum_reg <= tsum_next;
        norm_reg <= norm_next;
    end

    assign seed = seed_reg;
    assign norm = norm_reg;

endmodule

### hw/rtl/minimal_standard_lcg_with_normal.sv
// ----------------------------------------------------------------------------
// minimal_standard_lcg_with_normal
// Multiplicative congruential generator (x16807 mod 2^31-1) with a uniform
// draw and a six-term approximately normal draw, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Uniform request: one multiply-mod step, then the result is registered once
//   the output register is free; the next input is taken back in idle.
// Normal request: 6 multiply-mod steps through one shared unit, then 4 steps
//   of scaling and division; no new request is taken until it is emitted.
// A finished result waits in the output register while the next item runs.
// Reset (rst_n, async): seed and start_seed are 1, sequencer idle, no output.

module minimal_standard_lcg_with_normal
    import mslcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // request channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              want_normal,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SEED_W-1:0] new_seed,
    output logic [NORM_W-1:0] normal_value
);

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              mode_normal_reg, mode_normal_next;
    logic [SEED_W-1:0] start_seed_reg, start_seed_next;
    logic              out_valid_reg, out_valid_next;
    logic [SEED_W-1:0] new_seed_reg, new_seed_next;
    logic [NORM_W-1:0] normal_value_reg, normal_value_next;

    ctrl_word_t        word;
    logic              exec;
    logic              take;
    logic              out_free;
    logic              cfg_wr;
    dp_ctrl_t          dp_ctrl;
    logic [SEED_W-1:0] dp_seed;
    logic [NORM_W-1:0] dp_norm;

    // Control store fetch and handshake
    assign word     = ucode(pc_reg);
    assign in_stall = (word.cond != COND_TAKE);
    assign take     = in_valid && (word.cond == COND_TAKE);
    assign out_free = !out_valid_reg || !out_stall;

    // Configuration write
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_START_SEED);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_START_SEED) ? {1'b0, start_seed_reg} : '0;

    // Step sequencing
    always_comb
    begin
        exec    = 1'b1;
        pc_next = pc_reg;
        case (word.cond)
            COND_NEXT: pc_next = pc_reg + 1'b1;
            COND_TAKE:
            begin
                exec    = take;
                pc_next = take ? (pc_reg + 1'b1) : pc_reg;
            end
            COND_UNIF: pc_next = mode_normal_reg ? (pc_reg + 1'b1) : word.target;
            COND_FREE:
            begin
                exec    = out_free;
                pc_next = out_free ? word.target : pc_reg;
            end
            COND_JUMP: pc_next = word.target;
            default:   pc_next = PC_IDLE;
        endcase
    end

    // Datapath control
    always_comb
    begin
        dp_ctrl.op        = exec ? word.op : OP_NOP;
        dp_ctrl.seed_load = cfg_wr;
        dp_ctrl.seed_data = pwdata[SEED_W-1:0];
    end

    // Next values of the sequencer and output registers
    always_comb
    begin
        mode_normal_next  = take ? want_normal : mode_normal_reg;
        start_seed_next   = cfg_wr ? pwdata[SEED_W-1:0] : start_seed_reg;
        out_valid_next    = out_valid_reg && out_stall;
        new_seed_next     = new_seed_reg;
        normal_value_next = normal_value_reg;
        if (exec && word.emit)
        begin
            out_valid_next    = 1'b1;
            new_seed_next     = dp_seed;
            normal_value_next = dp_norm;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= PC_IDLE;
            mode_normal_reg <= 1'b0;
            start_seed_reg  <= {{(SEED_W-1){1'b0}}, 1'b1};
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pc_reg          <= pc_next;
            mode_normal_reg <= mode_normal_next;
            start_seed_reg  <= start_seed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        new_seed_reg     <= new_seed_next;
        normal_value_reg <= normal_value_next;
    end

    mslcg_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dp_ctrl),
        .seed  (dp_seed),
        .norm  (dp_norm)
    );

    assign out_valid    = out_valid_reg;
    assign new_seed     = new_seed_reg;
    assign normal_value = normal_value_reg;

    // Generator never reaches a fixed point of the recurrence
    a_seed_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_seed != '0) && (dp_seed != LCG_MOD))
        else $error("generator seed left its legal range");

    // An accepted request starts the first generator step next cycle
    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (pc_reg == PC_STEP_FIRST))
        else $error("request transfer did not start the step sequence");

    // Uniform requests carry a zero normal value
    a_uniform_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((pc_reg == PC_EMIT) && !mode_normal_reg) |-> (dp_norm == '0))
        else $error("uniform request with nonzero normal value");

    // After the emit step the sequencer is idle and the result is staged
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && word.emit) |=> (pc_reg == PC_IDLE) && out_valid_reg)
        else $error("result transfer not staged after emit step");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for minimal_standard_lcg_with_normal. A short table of
// directed requests and seed writes is followed by about 600 random requests
// in phases with different seeds and traffic shapes. Results of typed rows
// are compared against hand-read values, all others against an in-bench model
// of the x16807 mod 2^31-1 generator and its six-term normal draw.
// ----------------------------------------------------------------------------
module testbench
    import mslcg_pkg::*;
();

    // Request codes on want_normal
    localparam logic DRAW_UNIFORM = 1'b0;
    localparam logic DRAW_NORMAL  = 1'b1;

    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int SETTLE_CYCLES   = 16;
    localparam int LONG_HOLD       = 400;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [SEED_W-1:0] seed;
        logic [NORM_W-1:0] norm;
    } draw_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [DATA_W-1:0] wdata;
        logic              normal;
        logic              typed;
        logic [SEED_W-1:0] exp_seed;
        logic [NORM_W-1:0] exp_norm;
    } row_t;

    localparam int N_DIRECTED = 22;

    // Directed table; typed rows carry an expectation read off by hand
    localparam row_t DIRECTED [N_DIRECTED] = '{
        // out of reset the seed is 1
        '{ROW_REQ, 32'h0000_0000, DRAW_UNIFORM, 1'b1, 31'd16807,      32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_UNIFORM, 1'b1, 31'd282475249,  32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_NORMAL,  1'b0, 31'd0,          32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_NORMAL,  1'b0, 31'd0,          32'd0},
        // zero seed becomes one
        '{ROW_CFG, 32'h0000_0000, DRAW_UNIFORM, 1'b0, 31'd0,          32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_UNIFORM, 1'b1, 31'd16807,      32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_NORMAL,  1'b0, 31'd0,          32'd0},
        // seed equal to the modulus also becomes one
        '{ROW_CFG, 32'h7FFF_FFFF, DRAW_UNIFORM, 1'b0, 31'd0,          32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_UNIFORM, 1'b1, 31'd16807,      32'd0},
        // largest legal seed, i.e. -1 mod the modulus
        '{ROW_CFG, 32'h7FFF_FFFE, DRAW_UNIFORM, 1'b0, 31'd0,          32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_UNIFORM, 1'b1, 31'd2147466840, 32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_NORMAL,  1'b0, 31'd0,          32'd0},
        // bit 31 of the write data is dropped
        '{ROW_CFG, 32'hFFFF_FFFF, DRAW_UNIFORM, 1'b0, 31'd0,          32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_UNIFORM, 1'b1, 31'd16807,      32'd0},
        '{ROW_CFG, 32'h8000_0005, DRAW_UNIFORM, 1'b0, 31'd0,          32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_UNIFORM, 1'b1, 31'd84035,      32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_NORMAL,  1'b0, 31'd0,          32'd0},
        '{ROW_CFG, 32'h5555_5555, DRAW_UNIFORM, 1'b0, 31'd0,          32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_NORMAL,  1'b0, 31'd0,          32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_UNIFORM, 1'b0, 31'd0,          32'd0},
        '{ROW_CFG, 32'h2AAA_AAAA, DRAW_UNIFORM, 1'b0, 31'd0,          32'd0},
        '{ROW_REQ, 32'h0000_0000, DRAW_NORMAL,  1'b0, 31'd0,          32'd0}
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              want_normal;
    logic              out_valid;
    logic              out_stall;
    logic [SEED_W-1:0] new_seed;
    logic [NORM_W-1:0] normal_value;

    // Model state and expected results in flight
    logic [SEED_W-1:0] gen_seed;
    draw_t             pending_draws[$];

    // Traffic shaping
    bit tx_gaps_on;
    bit rx_stalls_on;
    bit rx_hold_req;
    bit rx_hold_seen;

    int mismatches;
    int n_checked;
    int n_uniform;
    int n_normal;
    int n_seed_writes;

    minimal_standard_lcg_with_normal u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .want_normal  (want_normal),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_seed     (new_seed),
        .normal_value (normal_value)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Generator model
    // ------------------------------------------------------------------
    function automatic logic [SEED_W-1:0] seed_sanitize(input logic [DATA_W-1:0] v);
        logic [SEED_W-1:0] s;
        s = v[SEED_W-1:0];
        if (s == LCG_MOD)
            s = '0;
        if (s == '0)
            s = SEED_W'(1);
        return s;
    endfunction

    function automatic logic [SEED_W-1:0] lcg_step(input logic [SEED_W-1:0] s);
        logic [63:0] p;
        p = 64'(LCG_MUL) * 64'(s);
        return SEED_W'(p % 64'(LCG_MOD));
    endfunction

    // Advance the model by one request and return the draw it yields
    function automatic draw_t next_draw(input logic normal);
        draw_t       d;
        logic [63:0] total;
        logic [63:0] mag;
        logic [63:0] q;
        logic        below;
        d.seed = seed_sanitize({1'b0, gen_seed});
        d.norm = '0;
        if (!normal)
            d.seed = lcg_step(d.seed);
        else
        begin
            total = '0;
            for (int i = 0; i < SUM_TERMS; i++)
            begin
                d.seed = lcg_step(d.seed);
                total  = total + 64'(d.seed);
            end
            below  = total < 64'(CENTRE);
            mag    = below ? 64'(CENTRE) - total : total - 64'(CENTRE);
            q      = (mag * 64'(SCALE_Q28)) / 64'(LCG_MOD);
            d.norm = below ? NORM_W'(0) - q[NORM_W-1:0] : q[NORM_W-1:0];
        end
        gen_seed = d.seed;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $realtime, what,
                     exp_v, act_v);
    endtask

    // APB write of start_seed; returns in the cycle after the access phase
    task automatic write_start_seed(input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_START_SEED;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= DATA_W'($urandom);
        gen_seed = seed_sanitize(value);
        n_seed_writes++;
        @(posedge clk);
    endtask

    // Offer one request, wait for the transfer, record what it should yield
    task automatic send_request(input logic normal, input bit typed,
                                input draw_t typed_draw);
        int    gap;
        draw_t d;
        gap = tx_gaps_on ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        want_normal <= normal;
        do
            @(posedge clk);
        while (in_stall);
        d = next_draw(normal);
        pending_draws.push_back(typed ? typed_draw : d);
        if (normal)
            n_normal++;
        else
            n_uniform++;
    endtask

    // Wait for every result, then let the sequencer settle
    task automatic drain_results();
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        draw_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_draws.size() == 0)
                note_mismatch("result with nothing outstanding", 64'd0,
                              64'({new_seed, normal_value}));
            else
            begin
                want = pending_draws.pop_front();
                n_checked++;
                if (new_seed !== want.seed)
                    note_mismatch("new_seed", 64'(want.seed), 64'(new_seed));
                if (normal_value !== want.norm)
                    note_mismatch("normal_value", 64'(want.norm), 64'(normal_value));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stalls, including one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_stalls
        int n;
        bit hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            hold = rx_hold_req;
            if (hold)
                n = LONG_HOLD;
            else if (rx_stalls_on)
                n = idle_len();
            else
                n = 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                if (hold)
                begin
                    rx_hold_req  = 1'b0;
                    rx_hold_seen = 1'b1;
                end
            end
            out_stall <= 1'b0;
            repeat (rx_stalls_on ? 1 + idle_len() : 1) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        draw_t       typed_draw;
        logic [31:0] phase_seed;
        int          normal_pct;
        logic        normal;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        want_normal  = DRAW_UNIFORM;
        gen_seed     = SEED_W'(1);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        rx_hold_req  = 1'b0;
        rx_hold_seen = 1'b0;
        mismatches   = 0;
        n_checked    = 0;
        n_uniform    = 0;
        n_normal     = 0;
        n_seed_writes = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                in_valid <= 1'b0;
                drain_results();
                write_start_seed(DIRECTED[i].wdata);
            end
            else
            begin
                typed_draw.seed = DIRECTED[i].exp_seed;
                typed_draw.norm = DIRECTED[i].exp_norm;
                send_request(DIRECTED[i].normal, DIRECTED[i].typed, typed_draw);
            end
        end

        // Random phases, each with a seed write and a traffic shape set by phase number
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            in_valid <= 1'b0;
            drain_results();
            case (p)
                1:       phase_seed = 32'h7FFF_FFFE;
                3:       phase_seed = 32'h0000_0001;
                default: phase_seed = $urandom;
            endcase
            write_start_seed(phase_seed);
            tx_gaps_on   = (p != 1) && (p != 4);
            rx_stalls_on = (p != 1) && (p != 3);
            if (p == 2)
                rx_hold_req = 1'b1;
            case (p)
                2:       normal_pct = 85;
                4:       normal_pct = 15;
                default: normal_pct = 50;
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                normal = ($urandom_range(0, 99) < normal_pct) ? DRAW_NORMAL : DRAW_UNIFORM;
                send_request(normal, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        drain_results();

        $display("Checked %0d results: %0d uniform and %0d normal requests, %0d seed writes.",
                 n_checked, n_uniform, n_normal, n_seed_writes);
        $display("Traffic mixed random gaps, gap-free stretches and a %0d-cycle hold-off (%s).",
                 LONG_HOLD, rx_hold_seen ? "done" : "not reached");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending_draws.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
